>>> rtl/dfl_pkg.sv
`timescale 1ns / 1ps

package dfl_pkg;

    // longest word in characters; further word characters are dropped
    localparam int MAX_WORD = 256;
    localparam int WL_W     = $clog2(MAX_WORD + 1);

    // bundles held between lexer front and result back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WL_W-1:0] wlen_t;

    typedef enum logic [2:0] {
        TK_CHAR     = 3'd0,
        TK_WORD_END = 3'd1,
        TK_EQUAL    = 3'd2,
        TK_LBRACE   = 3'd3,
        TK_RBRACE   = 3'd4,
        TK_EOF      = 3'd5
    } tk_kind_t;

    typedef enum logic [3:0] {
        MODE_NEUTRAL = 4'b0001,
        MODE_QUOTE   = 4'b0010,
        MODE_WORD    = 4'b0100,
        MODE_MACRO   = 4'b1000
    } lex_mode_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        tk_kind_t   kind;
        logic [7:0] ch;
    } item_t;

    // up to three results from one byte, in delivery order from index 0
    typedef struct packed {
        logic [1:0]      count;
        item_t [2:0]     item;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/display_file_lexer_unit.sv
`timescale 1ns / 1ps

// Display file lexer: takes one text byte per transaction (or an end-of-input
// marker) and turns it into zero to three result transactions: word
// characters, word end, '=', '{', '}' and end of file, with m_last set on the
// final result of each byte. $(name) text passes through as word characters;
// characters past MAX_WORD in one word are dropped. A byte is accepted every
// cycle while the four-entry bundle queue between the lexer front and the
// result back end has room; the back end hands out one result per cycle
// while the queue holds bundles and m_ready is high, so the results of one
// byte leave one at a time and the output port sets the sustained rate when
// multi-result bytes cluster. A taken byte's results are written into the
// bundle queue and then pass through the output register.

module display_file_lexer_unit import dfl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_kind,
    output logic [7:0] m_word_char,
    output logic       m_last
);

    q_status_t q_status;
    logic      push;
    bundle_t   push_data;
    logic      pop;
    bundle_t   head;

    // front: mode machine, word length limit, packs each byte's results
    dfl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_end_of_input (s_end_of_input),
        .q_status       (q_status),
        .push           (push),
        .push_data      (push_data)
    );

    // decouples byte intake from result delivery
    dfl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    // back: unpacks a bundle into single results through an output register
    dfl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_kind (m_token_kind),
        .m_word_char  (m_word_char),
        .m_last       (m_last)
    );

endmodule

>>> rtl/dfl_front.sv
`timescale 1ns / 1ps

module dfl_front import dfl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_end_of_input,
    input  q_status_t  q_status,
    output logic       push,
    output bundle_t    push_data
);

    lex_mode_t mode_reg, mode_next;
    logic      rtq_reg, rtq_next;
    logic      dp_reg, dp_next;
    wlen_t     wl_reg, wl_next;

    bundle_t   plan;
    bundle_t   emit;
    logic      quote_c;
    logic      accept;

    function automatic bundle_t add_item(bundle_t b, tk_kind_t k, logic [7:0] c);
        bundle_t r;
        r = b;
        if (b.count != 2'd3) begin
            r.item[b.count].kind = k;
            r.item[b.count].ch   = (k == TK_CHAR) ? c : 8'h00;
            r.count              = b.count + 2'd1;
        end
        return r;
    endfunction

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // first pass: results the byte asks for, and the new mode bits
    always_comb begin
        plan      = '0;
        mode_next = mode_reg;
        rtq_next  = rtq_reg;
        dp_next   = dp_reg;
        quote_c   = 1'b1;
        if (s_end_of_input) begin
            plan      = add_item(plan, TK_EOF, 8'h00);
            mode_next = MODE_NEUTRAL;
            rtq_next  = 1'b0;
            dp_next   = 1'b0;
        end else begin
            unique case (mode_reg)
                MODE_NEUTRAL: begin
                    if (dp_reg) begin
                        plan    = add_item(plan, TK_CHAR, CH_DOLLAR);
                        plan    = add_item(plan, TK_CHAR, s_character);
                        dp_next = 1'b0;
                        if (s_character == CH_LPAREN) begin
                            mode_next = MODE_MACRO;
                            rtq_next  = 1'b0;
                        end
                    end else begin
                        unique case (s_character) inside
                            CH_EQUAL, CH_LBRACE, CH_RBRACE: begin
                                if (s_character == CH_EQUAL)
                                    plan = add_item(plan, TK_EQUAL, 8'h00);
                                else if (s_character == CH_LBRACE)
                                    plan = add_item(plan, TK_LBRACE, 8'h00);
                                else
                                    plan = add_item(plan, TK_RBRACE, 8'h00);
                                mode_next = MODE_NEUTRAL;
                                rtq_next  = 1'b0;
                                dp_next   = 1'b0;
                            end
                            CH_QUOTE:  mode_next = MODE_QUOTE;
                            CH_DOLLAR: dp_next = 1'b1;
                            CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                            end
                            CH_LPAREN, CH_COMMA, CH_RPAREN: begin
                                plan      = add_item(plan, TK_CHAR, s_character);
                                plan      = add_item(plan, TK_WORD_END, 8'h00);
                                mode_next = MODE_NEUTRAL;
                                rtq_next  = 1'b0;
                                dp_next   = 1'b0;
                            end
                            default: begin
                                plan      = add_item(plan, TK_CHAR, s_character);
                                mode_next = MODE_WORD;
                            end
                        endcase
                    end
                end
                MODE_QUOTE: begin
                    if (dp_reg) begin
                        plan    = add_item(plan, TK_CHAR, CH_DOLLAR);
                        dp_next = 1'b0;
                        if (s_character == CH_LPAREN) begin
                            plan      = add_item(plan, TK_CHAR, s_character);
                            mode_next = MODE_MACRO;
                            rtq_next  = 1'b1;
                            quote_c   = 1'b0;
                        end
                    end
                    if (quote_c) begin
                        if (s_character == CH_QUOTE) begin
                            plan      = add_item(plan, TK_WORD_END, 8'h00);
                            mode_next = MODE_NEUTRAL;
                            rtq_next  = 1'b0;
                            dp_next   = 1'b0;
                        end else if (s_character == CH_DOLLAR) begin
                            dp_next = 1'b1;
                        end else begin
                            plan = add_item(plan, TK_CHAR, s_character);
                        end
                    end
                end
                MODE_WORD: begin
                    unique case (s_character) inside
                        CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_QUOTE, CH_EQUAL,
                        CH_LPAREN, CH_COMMA, CH_RPAREN: begin
                            // word closes, delimiter handled again as neutral
                            plan      = add_item(plan, TK_WORD_END, 8'h00);
                            mode_next = MODE_NEUTRAL;
                            rtq_next  = 1'b0;
                            dp_next   = 1'b0;
                            if (s_character == CH_QUOTE) begin
                                mode_next = MODE_QUOTE;
                            end else if (s_character == CH_EQUAL) begin
                                plan = add_item(plan, TK_EQUAL, 8'h00);
                            end else if (s_character == CH_LPAREN ||
                                         s_character == CH_COMMA ||
                                         s_character == CH_RPAREN) begin
                                plan = add_item(plan, TK_CHAR, s_character);
                                plan = add_item(plan, TK_WORD_END, 8'h00);
                            end
                        end
                        default: plan = add_item(plan, TK_CHAR, s_character);
                    endcase
                end
                MODE_MACRO: begin
                    plan = add_item(plan, TK_CHAR, s_character);
                    if (s_character == CH_RPAREN) begin
                        mode_next = rtq_reg ? MODE_QUOTE : MODE_NEUTRAL;
                        rtq_next  = 1'b0;
                    end
                end
                default: begin
                    mode_next = MODE_NEUTRAL;
                    rtq_next  = 1'b0;
                    dp_next   = 1'b0;
                end
            endcase
        end
    end

    // second pass: word length limit, tokens restart the count
    always_comb begin
        emit    = '0;
        wl_next = wl_reg;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < plan.count) begin
                if (plan.item[i].kind == TK_CHAR) begin
                    if (wl_next < WL_W'(MAX_WORD)) begin
                        emit    = add_item(emit, TK_CHAR, plan.item[i].ch);
                        wl_next = wl_next + 1'b1;
                    end
                end else begin
                    emit    = add_item(emit, plan.item[i].kind, 8'h00);
                    wl_next = '0;
                end
            end
        end
    end

    assign push      = accept && (emit.count != 2'd0);
    assign push_data = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NEUTRAL;
            rtq_reg  <= 1'b0;
            dp_reg   <= 1'b0;
            wl_reg   <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            rtq_reg  <= rtq_next;
            dp_reg   <= dp_next;
            wl_reg   <= wl_next;
        end
    end

endmodule

>>> rtl/dfl_queue.sv
`timescale 1ns / 1ps

module dfl_queue import dfl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  bundle_t   push_data,
    input  logic      pop,
    output q_status_t status,
    output bundle_t   head
);

    bundle_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/dfl_back.sv
`timescale 1ns / 1ps

module dfl_back import dfl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  q_status_t  q_status,
    input  bundle_t    head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_kind,
    output logic [7:0] m_word_char,
    output logic       m_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    tk_kind_t   kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_end;

    assign load   = !q_status.empty && (!valid_reg || m_ready);
    assign at_end = (idx_reg == head.count - 2'd1);
    assign pop    = load && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        kind_next  = kind_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            kind_next  = head.item[idx_reg].kind;
            char_next  = head.item[idx_reg].ch;
            last_next  = at_end;
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_token_kind = kind_reg;
    assign m_word_char  = char_reg;
    assign m_last       = last_reg;

endmodule
